/* rtl/dmkvc_pkg.sv */
// ----------------------------------------------------------------------------
// dmkvc_pkg
// Shared types, codes and constants of the direct-mapped key/value cache.
// ----------------------------------------------------------------------------
package dmkvc_pkg;

  localparam int unsigned EntriesDefault    = 256;
  localparam int unsigned KeyBytesDefault   = 8;
  localparam int unsigned ValueBytesDefault = 8;

  localparam int unsigned FieldW   = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CountW   = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned HashW    = 32;

  localparam logic [HashW-1:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [HashW-1:0] FnvPrime = 32'h0100_0193;

  localparam int unsigned ModBitsPerStep = 8;
  localparam int unsigned ModSteps       = HashW / ModBitsPerStep;
  localparam int unsigned StepW          = $clog2(ModSteps);

  typedef enum logic [1:0] {
    ModeLookup,
    ModeStore,
    ModeRemove,
    ModeClear
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk,
    StatusBadKeyLen,
    StatusSizeErr,
    StatusNotFound
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEntryCount,
    CfgKeyLimit,
    CfgValueLimit
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StHash,
    StMod,
    StRead,
    StResolve,
    StEmit
  } state_e;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] read_value;
    logic [LenW-1:0]   read_length;
    logic              updated;
    logic              evicted;
  } result_t;

  function automatic logic [FieldW-1:0] byte_mask(input logic [LenW-1:0] n);
    logic [FieldW-1:0] m;
    m = '0;
    for (int i = 0; i < FieldW / 8; i++) begin
      if (LenW'(i) < n) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/direct_mapped_key_value_cache.sv */
// ----------------------------------------------------------------------------
// direct_mapped_key_value_cache
// Lookup/store/remove/clear on one slot memory indexed by FNV-1a-32 mod count.
// A request hashes one key byte per cycle, reduces 8 remainder bits per cycle,
// reads its slot and writes it back on a store or a removal hit; a length error
// skips to the result and a clear sweeps all slots. No new request is taken
// until the last result is loaded for output. Reset: restores register defaults,
// then sweeps all ENTRIES slots (no request taken) to drop the valid flags.
// ----------------------------------------------------------------------------
module direct_mapped_key_value_cache #(
  parameter int unsigned ENTRIES     = dmkvc_pkg::EntriesDefault,
  parameter int unsigned KEY_BYTES   = dmkvc_pkg::KeyBytesDefault,
  parameter int unsigned VALUE_BYTES = dmkvc_pkg::ValueBytesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dmkvc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [dmkvc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        mode_i,
  input  logic [dmkvc_pkg::FieldW-1:0]      key_i,
  input  logic [dmkvc_pkg::LenW-1:0]        key_length_i,
  input  logic [dmkvc_pkg::FieldW-1:0]      store_value_i,
  input  logic [dmkvc_pkg::LenW-1:0]        store_length_i,
  input  logic [dmkvc_pkg::LenW-1:0]        read_capacity_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [dmkvc_pkg::FieldW-1:0]      read_value_o,
  output logic [dmkvc_pkg::LenW-1:0]        read_length_o,
  output logic                              updated_same_key_o,
  output logic                              evicted_other_key_o
);

  localparam int unsigned AddrW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KeyStW = 8 * KEY_BYTES;
  localparam int unsigned ValStW = 8 * VALUE_BYTES;
  localparam int unsigned LenW   = dmkvc_pkg::LenW;
  localparam int unsigned CountW = dmkvc_pkg::CountW;
  localparam int unsigned HashW  = dmkvc_pkg::HashW;
  localparam int unsigned StepW  = dmkvc_pkg::StepW;
  localparam logic [AddrW-1:0] SweepLast = AddrW'(ENTRIES - 1);
  localparam logic [StepW-1:0] StepLast  = StepW'(dmkvc_pkg::ModSteps - 1);

  typedef struct packed {
    logic              valid;
    logic [HashW-1:0]  hash;
    logic [LenW-1:0]   key_length;
    logic [KeyStW-1:0] key;
    logic [LenW-1:0]   value_length;
    logic [ValStW-1:0] value;
  } entry_t;

  entry_t slot_mem [ENTRIES];

  dmkvc_pkg::state_e  state_q, state_d;
  dmkvc_pkg::mode_e   mode_q, mode_d;
  dmkvc_pkg::result_t res_q, res_d, out_q;
  dmkvc_pkg::status_e chk_status;

  logic [CountW-1:0] entry_count_q, count_eff, count_q, count_d;
  logic [LenW-1:0]   key_limit_q, value_limit_q, klim_eff, vlim_eff;
  logic [KeyStW-1:0] key_q, key_d, hkey_q, hkey_d;
  logic [ValStW-1:0] sval_q, sval_d;
  logic [LenW-1:0]   klen_q, klen_d, slen_q, slen_d, cap_q, cap_d, hleft_q, hleft_d;
  logic [HashW-1:0]  hash_q, hash_d, dvd_q, dvd_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [AddrW-1:0]  idx_q, idx_d, sweep_q, sweep_d, mem_waddr;
  logic              sweep_op_q, sweep_op_d, out_valid_q, out_valid_d, out_load;
  logic              chk_err, hit, mem_we;
  entry_t            rd_q, mem_wdata;

  // Effective configuration
  always_comb begin
    if (entry_count_q == '0) begin
      count_eff = CountW'(1);
    end else if (32'(entry_count_q) > ENTRIES) begin
      count_eff = CountW'(ENTRIES);
    end else begin
      count_eff = entry_count_q;
    end
    klim_eff = (32'(key_limit_q) > KEY_BYTES) ? LenW'(KEY_BYTES) : key_limit_q;
    vlim_eff = (32'(value_limit_q) > VALUE_BYTES) ? LenW'(VALUE_BYTES) : value_limit_q;
  end

  always_comb begin
    chk_err    = 1'b1;
    chk_status = dmkvc_pkg::StatusSizeErr;
    priority if (key_length_i == '0) begin
      chk_status = dmkvc_pkg::StatusBadKeyLen;
    end else if (key_length_i > klim_eff) begin
      chk_status = dmkvc_pkg::StatusSizeErr;
    end else if (mode_i == dmkvc_pkg::ModeStore && store_length_i > vlim_eff) begin
      chk_status = dmkvc_pkg::StatusSizeErr;
    end else begin
      chk_err    = 1'b0;
      chk_status = dmkvc_pkg::StatusOk;
    end
  end

  assign hit = rd_q.valid && rd_q.hash == hash_q && rd_q.key_length == klen_q &&
               rd_q.key == key_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dmkvc_pkg::StIdle: begin
        if (in_valid_i) begin
          if (mode_i == dmkvc_pkg::ModeClear) begin
            state_d = dmkvc_pkg::StClear;
          end else if (chk_err) begin
            state_d = dmkvc_pkg::StEmit;
          end else begin
            state_d = dmkvc_pkg::StHash;
          end
        end
      end
      dmkvc_pkg::StClear: begin
        if (sweep_q == SweepLast) begin
          state_d = sweep_op_q ? dmkvc_pkg::StEmit : dmkvc_pkg::StIdle;
        end
      end
      dmkvc_pkg::StHash: begin
        if (hleft_q == LenW'(1)) begin
          state_d = dmkvc_pkg::StMod;
        end
      end
      dmkvc_pkg::StMod: begin
        if (step_q == StepLast) begin
          state_d = dmkvc_pkg::StRead;
        end
      end
      dmkvc_pkg::StRead:    state_d = dmkvc_pkg::StResolve;
      dmkvc_pkg::StResolve: state_d = dmkvc_pkg::StEmit;
      dmkvc_pkg::StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = dmkvc_pkg::StIdle;
        end
      end
      default: state_d = dmkvc_pkg::StIdle;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    logic [CountW-1:0] rem_v;
    logic [HashW-1:0]  dvd_v;
    logic [CountW:0]   trial;
    mode_d     = mode_q;
    key_d      = key_q;
    hkey_d     = hkey_q;
    klen_d     = klen_q;
    sval_d     = sval_q;
    slen_d     = slen_q;
    cap_d      = cap_q;
    count_d    = count_q;
    hash_d     = hash_q;
    hleft_d    = hleft_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    step_d     = step_q;
    idx_d      = idx_q;
    sweep_d    = sweep_q;
    sweep_op_d = sweep_op_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = '0;
    out_load   = 1'b0;
    rem_v      = rem_q;
    dvd_v      = dvd_q;
    trial      = '0;
    unique case (state_q)
      dmkvc_pkg::StIdle: begin
        if (in_valid_i) begin
          mode_d     = dmkvc_pkg::mode_e'(mode_i);
          key_d      = KeyStW'(key_i & dmkvc_pkg::byte_mask(key_length_i));
          hkey_d     = KeyStW'(key_i & dmkvc_pkg::byte_mask(key_length_i));
          klen_d     = key_length_i;
          sval_d     = ValStW'(store_value_i & dmkvc_pkg::byte_mask(store_length_i));
          slen_d     = store_length_i;
          cap_d      = read_capacity_i;
          count_d    = count_eff;
          hash_d     = dmkvc_pkg::FnvBasis;
          hleft_d    = key_length_i;
          step_d     = '0;
          sweep_d    = '0;
          sweep_op_d = 1'b1;
          res_d      = '0;
          if (mode_i != dmkvc_pkg::ModeClear) begin
            res_d.status = chk_status;
          end
        end
      end
      dmkvc_pkg::StClear: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        sweep_d   = sweep_q + AddrW'(1);
      end
      dmkvc_pkg::StHash: begin
        hash_d  = (hash_q ^ {24'b0, hkey_q[7:0]}) * dmkvc_pkg::FnvPrime;
        hkey_d  = hkey_q >> 8;
        hleft_d = hleft_q - LenW'(1);
        dvd_d   = hash_d;
        rem_d   = '0;
        step_d  = '0;
      end
      dmkvc_pkg::StMod: begin
        for (int b = 0; b < dmkvc_pkg::ModBitsPerStep; b++) begin
          trial = {rem_v, dvd_v[HashW-1]};
          dvd_v = dvd_v << 1;
          if (trial >= {1'b0, count_q}) begin
            trial = trial - {1'b0, count_q};
          end
          rem_v = trial[CountW-1:0];
        end
        rem_d  = rem_v;
        dvd_d  = dvd_v;
        step_d = step_q + StepW'(1);
        idx_d  = AddrW'(rem_v);
      end
      dmkvc_pkg::StRead: begin
        res_d = '0;
      end
      dmkvc_pkg::StResolve: begin
        unique case (mode_q)
          dmkvc_pkg::ModeLookup: begin
            if (!hit) begin
              res_d.status = dmkvc_pkg::StatusNotFound;
            end else if (cap_q < rd_q.value_length) begin
              res_d.status      = dmkvc_pkg::StatusSizeErr;
              res_d.read_length = rd_q.value_length;
            end else begin
              res_d.read_length = rd_q.value_length;
              res_d.read_value  = dmkvc_pkg::FieldW'(rd_q.value);
            end
          end
          dmkvc_pkg::ModeStore: begin
            res_d.updated = hit;
            res_d.evicted = !hit && rd_q.valid;
            mem_we        = 1'b1;
            mem_wdata     = '{valid: 1'b1, hash: hash_q, key_length: klen_q, key: key_q,
                              value_length: slen_q, value: sval_q};
          end
          dmkvc_pkg::ModeRemove: begin
            if (hit) begin
              mem_we          = 1'b1;
              mem_wdata       = rd_q;
              mem_wdata.valid = 1'b0;
            end else begin
              res_d.status = dmkvc_pkg::StatusNotFound;
            end
          end
          default: res_d = '0;
        endcase
      end
      dmkvc_pkg::StEmit: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: res_d = res_q;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dmkvc_pkg::StClear;
      out_valid_q   <= 1'b0;
      sweep_q       <= '0;
      sweep_op_q    <= 1'b0;
      hleft_q       <= '0;
      step_q        <= '0;
      entry_count_q <= CountW'(256);
      key_limit_q   <= LenW'(8);
      value_limit_q <= LenW'(8);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sweep_q     <= sweep_d;
      sweep_op_q  <= sweep_op_d;
      hleft_q     <= hleft_d;
      step_q      <= step_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == dmkvc_pkg::CfgEntryCount) begin
          entry_count_q <= cfg_wdata_i[CountW-1:0];
        end else if (cfg_idx_i == dmkvc_pkg::CfgKeyLimit) begin
          key_limit_q <= cfg_wdata_i[LenW-1:0];
        end else if (cfg_idx_i == dmkvc_pkg::CfgValueLimit) begin
          value_limit_q <= cfg_wdata_i[LenW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    key_q   <= key_d;
    hkey_q  <= hkey_d;
    klen_q  <= klen_d;
    sval_q  <= sval_d;
    slen_q  <= slen_d;
    cap_q   <= cap_d;
    count_q <= count_d;
    hash_q  <= hash_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    idx_q   <= idx_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= slot_mem[idx_q];
  end

  assign in_ready_o          = (state_q == dmkvc_pkg::StIdle);
  assign out_valid_o         = out_valid_q;
  assign status_o            = out_q.status;
  assign read_value_o        = out_q.read_value;
  assign read_length_o       = out_q.read_length;
  assign updated_same_key_o  = out_q.updated;
  assign evicted_other_key_o = out_q.evicted;

  a_one_request_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_resolve_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dmkvc_pkg::StResolve |=> state_q == dmkvc_pkg::StEmit)
    else $error("resolve not followed by emit");

  a_update_evict_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(updated_same_key_o && evicted_other_key_o))
    else $error("store flagged both update and eviction");

  a_value_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != dmkvc_pkg::StatusOk) |-> read_value_o == '0)
    else $error("read value nonzero on failed request");

endmodule
